FILE: rtl/core/wsdf_pkg.sv
package wsdf_pkg;

  // Frame opcodes that the parser acts on.
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  // Length code that announces a 16-bit extended length.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;

  // First byte of an echoed ping (FIN set, pong opcode).
  localparam logic [7:0] PONG_HEADER = 8'h8A;

  // Result kinds carried on the master-side tuser.
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_PONG  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Output queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // One beat taken from the slave side.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       link_down;
  } in_beat_t;

  // One result beat for the master side.
  typedef struct packed {
    logic       last;
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

endpackage

FILE: rtl/core/websocket_frame_deframer_unmasker.sv
// An accepted beat is registered in the input stage and parsed there; its results are written into a
// four-entry output queue once the queue has room, and the master side reads them from that queue.
// Throughput: one input beat per cycle. A ping's second byte yields two result beats, so the
// master side (one beat per cycle) and the queue's free space set the sustained input rate.
// Reset (rst, synchronous, active high) empties the input stage and the output queue and
// returns the parser to waiting for the first header byte of a frame.
module websocket_frame_deframer_unmasker #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // chunk_end
  input  logic       s_axis_tuser,   // [0] link_down

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last_of_run
);

  // Parser phases, one-hot. Each frame walks through the header phases and then
  // either streams text, echoes a ping, or skips to the end of the chunk.
  typedef enum logic [6:0] {
    PH_FIRST  = 7'b0000001,
    PH_SECOND = 7'b0000010,
    PH_EXTLEN = 7'b0000100,
    PH_MASK   = 7'b0001000,
    PH_TEXT   = 7'b0010000,
    PH_ECHO   = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_t;

  // ---------------------------------------------------------------------------
  // Input stage. A beat is held here while it is parsed. It moves on as
  // soon as the output queue has room for the two results a beat can produce.
  // ---------------------------------------------------------------------------
  wsdf_pkg::in_beat_t in_beat;
  logic               in_valid;
  logic               fire;
  logic               queue_room;

  logic [wsdf_pkg::QUEUE_CNT_W-1:0] q_count;

  assign queue_room    = (q_count <= wsdf_pkg::QUEUE_CNT_W'(wsdf_pkg::QUEUE_DEPTH - 2));
  assign fire          = in_valid && queue_room;
  assign s_axis_tready = !in_valid || queue_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_beat.data      <= s_axis_tdata;
      in_beat.last      <= s_axis_tlast;
      in_beat.link_down <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state.
  // ---------------------------------------------------------------------------
  phase_t                 phase,        phase_next;
  logic [3:0]             opcode,       opcode_next;
  logic                   mask_present, mask_present_next;
  logic [LENGTH_BITS-1:0] pay_len,      pay_len_next;
  logic [7:0]             len_hi,       len_hi_next;
  logic [31:0]            mask_key,     mask_key_next;
  logic [1:0]             hdr_idx,      hdr_idx_next;
  logic [LENGTH_BITS-1:0] pay_cnt,      pay_cnt_next;

  // Results of the beat in the input stage (up to two).
  wsdf_pkg::result_t res0, res1;
  logic [1:0]        res_n;

  // Helper values for the header and payload phases.
  logic [15:0]            ext_full;
  logic                   ext_sat;
  logic [LENGTH_BITS-1:0] ext_len;
  logic [LENGTH_BITS-1:0] short_len;
  logic [1:0]             key_sel;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS:0]   cnt_inc;
  logic                   text_done;

  // The 16-bit extended length saturates when it does not fit LENGTH_BITS.
  assign ext_full  = {len_hi, in_beat.data};
  assign ext_sat   = |(ext_full >> LENGTH_BITS);
  assign ext_len   = ext_sat ? {LENGTH_BITS{1'b1}} : ext_full[LENGTH_BITS-1:0];
  assign short_len = LENGTH_BITS'(in_beat.data[6:0]);

  // The key is stored first byte in the top bits, so payload byte n uses
  // key byte (n mod 4) counted from the top.
  assign key_sel   = 2'd3 - pay_cnt[1:0];
  assign key_byte  = mask_key[{key_sel, 3'b000} +: 8];
  assign cnt_inc   = {1'b0, pay_cnt} + (LENGTH_BITS + 1)'(1);
  assign text_done = (cnt_inc >= {1'b0, pay_len});

  always_comb begin
    phase_next        = phase;
    opcode_next       = opcode;
    mask_present_next = mask_present;
    pay_len_next      = pay_len;
    len_hi_next       = len_hi;
    mask_key_next     = mask_key;
    hdr_idx_next      = hdr_idx;
    pay_cnt_next      = pay_cnt;
    res0              = '0;
    res1              = '0;
    res_n             = 2'd0;

    if (in_beat.link_down) begin
      // A link error drops any partial chunk and asks for a close.
      res0.kind   = wsdf_pkg::KIND_CLOSE;
      res0.last   = 1'b1;
      res_n       = 2'd1;
      phase_next  = PH_FIRST;
    end else begin
      case (phase)
        PH_FIRST: begin
          opcode_next = in_beat.data[3:0];
          phase_next  = PH_SECOND;
        end
        PH_SECOND: begin
          // An unmasked frame unmasks with an all-zero key.
          mask_present_next = in_beat.data[7];
          pay_len_next      = short_len;
          mask_key_next     = '0;
          hdr_idx_next      = 2'd0;
          pay_cnt_next      = '0;
          if (opcode == wsdf_pkg::OPC_CLOSE) begin
            res0.kind  = wsdf_pkg::KIND_CLOSE;
            res0.last  = 1'b1;
            res_n      = 2'd1;
            phase_next = PH_SKIP;
          end else if (opcode == wsdf_pkg::OPC_PING) begin
            // Echo starts with the pong header, then the length byte as received.
            res0.kind  = wsdf_pkg::KIND_PONG;
            res0.data  = wsdf_pkg::PONG_HEADER;
            res1.kind  = wsdf_pkg::KIND_PONG;
            res1.data  = in_beat.data;
            res1.last  = in_beat.last;
            res_n      = 2'd2;
            phase_next = PH_ECHO;
          end else if (opcode == wsdf_pkg::OPC_TEXT) begin
            if (in_beat.data[6:0] == wsdf_pkg::LEN_CODE_EXT16) begin
              phase_next = PH_EXTLEN;
            end else if (in_beat.data[7]) begin
              phase_next = PH_MASK;
            end else begin
              phase_next = (short_len == '0) ? PH_SKIP : PH_TEXT;
            end
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_EXTLEN: begin
          if (hdr_idx == 2'd0) begin
            len_hi_next  = in_beat.data;
            hdr_idx_next = 2'd1;
          end else begin
            pay_len_next = ext_len;
            hdr_idx_next = 2'd0;
            pay_cnt_next = '0;
            if (mask_present) begin
              phase_next = PH_MASK;
            end else begin
              phase_next = (ext_len == '0) ? PH_SKIP : PH_TEXT;
            end
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_beat.data};
          hdr_idx_next  = hdr_idx + 2'd1;
          if (hdr_idx == 2'd3) begin
            pay_cnt_next = '0;
            phase_next   = (pay_len == '0) ? PH_SKIP : PH_TEXT;
          end
        end
        PH_TEXT: begin
          pay_cnt_next = cnt_inc[LENGTH_BITS-1:0];
          res0.kind    = wsdf_pkg::KIND_TEXT;
          res0.data    = in_beat.data ^ key_byte;
          res0.last    = text_done || in_beat.last;
          res_n        = 2'd1;
          if (text_done) begin
            phase_next = PH_SKIP;
          end
        end
        PH_ECHO: begin
          res0.kind = wsdf_pkg::KIND_PONG;
          res0.data = in_beat.data;
          res0.last = in_beat.last;
          res_n     = 2'd1;
        end
        default: begin
          // Skip phase: bytes up to the chunk end are dropped.
        end
      endcase

      // Every chunk end brings the parser back to a new frame header.
      if (in_beat.last) begin
        phase_next = PH_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FIRST;
      hdr_idx <= 2'd0;
      pay_cnt <= '0;
    end else if (fire) begin
      phase   <= phase_next;
      hdr_idx <= hdr_idx_next;
      pay_cnt <= pay_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      opcode       <= opcode_next;
      mask_present <= mask_present_next;
      pay_len      <= pay_len_next;
      len_hi       <= len_hi_next;
      mask_key     <= mask_key_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue. Up to two results are written per cycle and one is read.
  // ---------------------------------------------------------------------------
  wsdf_pkg::result_t                q_mem [wsdf_pkg::QUEUE_DEPTH];
  logic [wsdf_pkg::QUEUE_PTR_W-1:0] q_wr_ptr;
  logic [wsdf_pkg::QUEUE_PTR_W-1:0] q_rd_ptr;
  logic [1:0]                       push_n;
  logic                             pop;

  assign push_n = fire ? res_n : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      q_wr_ptr <= q_wr_ptr + wsdf_pkg::QUEUE_PTR_W'(push_n);
      q_rd_ptr <= q_rd_ptr + wsdf_pkg::QUEUE_PTR_W'(pop);
      q_count  <= q_count + wsdf_pkg::QUEUE_CNT_W'(push_n)
                - wsdf_pkg::QUEUE_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[q_wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      q_mem[q_wr_ptr + wsdf_pkg::QUEUE_PTR_W'(1)] <= res1;
    end
  end

  assign m_axis_tvalid = (q_count != '0);
  assign m_axis_tdata  = q_mem[q_rd_ptr].data;
  assign m_axis_tuser  = q_mem[q_rd_ptr].kind;
  assign m_axis_tlast  = q_mem[q_rd_ptr].last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The queue never holds more beats than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    q_count <= wsdf_pkg::QUEUE_CNT_W'(wsdf_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  // While text streams, the count of bytes sent stays below the frame length.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TEXT) |-> (pay_cnt < pay_len))
    else $error("text payload count ran past the frame length");

  // A link error always sends the parser back to a frame header.
  assert property (@(posedge clk) disable iff (rst)
    (fire && in_beat.link_down) |=> (phase == PH_FIRST))
    else $error("parser did not restart after a link error");

  // A parsed link error always leaves a close request in the queue.
  assert property (@(posedge clk) disable iff (rst)
    (fire && in_beat.link_down) |=> (q_count != '0))
    else $error("close request lost after a link error");

endmodule
